### sv/bpu_pkg.sv
// shared types, constants and the divide step of the bitfield pixel unpacker
package bpu_pkg;

   localparam logic [12:0] BPU_MAX_WIDTH  = 13'd4096;
   localparam logic [12:0] BPU_MAX_HEIGHT = 13'd4096;
   localparam logic [2:0]  BPU_MAX_BPP    = 3'd4;

   localparam int BPU_CHANNELS    = 4;
   localparam int BPU_CH_RED      = 0;
   localparam int BPU_CH_GREEN    = 1;
   localparam int BPU_CH_BLUE     = 2;
   localparam int BPU_CH_ALPHA    = 3;

   localparam int BPU_QUEUE_DEPTH = 4;
   localparam int BPU_QPTR_W      = $clog2(BPU_QUEUE_DEPTH);
   localparam int BPU_QCNT_W      = $clog2(BPU_QUEUE_DEPTH + 1);

   localparam int BPU_QUOT_BITS   = 8;
   localparam int BPU_STEP_W      = $clog2(BPU_QUOT_BITS);

   typedef enum logic [2:0] {
      BPU_REG_WIDTH       = 3'd0,
      BPU_REG_HEIGHT      = 3'd1,
      BPU_REG_BPP         = 3'd2,
      BPU_REG_BOTTOM_UP   = 3'd3,
      BPU_REG_RED_MASK    = 3'd4,
      BPU_REG_GREEN_MASK  = 3'd5,
      BPU_REG_BLUE_MASK   = 3'd6,
      BPU_REG_ALPHA_MASK  = 3'd7
   } bpu_reg_type;

   // geometry after range clamping
   typedef struct packed {
      logic [12:0] width;
      logic [12:0] height;
      logic [2:0]  bpp;
      logic        bottom_up;
   } bpu_geom_type;

   typedef logic [BPU_CHANNELS-1:0][31:0] bpu_masks_type;

   // one assembled pixel on its way to the scaler
   typedef struct packed {
      logic [31:0] word;
      logic [11:0] dst_row;
      logic [11:0] column;
      logic        last;
   } bpu_task_type;

   typedef struct packed {
      logic [31:0] rem;
      logic        qbit;
   } bpu_div_type;

   // one restoring division step, remainder stays below the divisor
   function automatic bpu_div_type bpu_div_step(logic [31:0] rem, logic next_bit,
                                                logic [31:0] divisor);
      logic [32:0]  trial;
      bpu_div_type  res;
      trial = {rem, next_bit};
      if (trial >= {1'b0, divisor}) begin
         res.rem  = 32'(trial - {1'b0, divisor});
         res.qbit = 1'b1;
      end else begin
         res.rem  = trial[31:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage

### sv/bpu_front.sv
// byte assembly, padding skip and row/column tracking
module bpu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  bpu_pkg::bpu_geom_type geom,
   input  logic                  req_valid,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_frame_start,
   output logic                  req_stall,
   input  logic                  queue_full,
   output logic                  push,
   output bpu_pkg::bpu_task_type push_task
);
   import bpu_pkg::*;

   logic [23:0] acc_ff, acc_in;
   logic [1:0]  bip_ff, bip_in;
   logic [13:0] bir_ff, bir_in;
   logic [11:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;

   logic [23:0] acc_cur;
   logic [1:0]  bip_cur;
   logic [13:0] bir_cur;
   logic [11:0] col_cur;
   logic [11:0] row_cur;
   logic [14:0] data_bytes;
   logic [14:0] row_bytes;
   logic [14:0] bir_inc;
   logic [31:0] word;
   logic        accept;
   logic        in_data;
   logic        last_byte;
   logic        emit;
   logic [11:0] wm1, hm1, r, c, row_nxt;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      // frame start clears everything before the byte is used
      acc_cur = req_frame_start ? '0 : acc_ff;
      bip_cur = req_frame_start ? '0 : bip_ff;
      bir_cur = req_frame_start ? '0 : bir_ff;
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;

      case (geom.bpp)
         3'd1:    data_bytes = {2'b00, geom.width};
         3'd2:    data_bytes = {1'b0, geom.width, 1'b0};
         3'd3:    data_bytes = {2'b00, geom.width} + {1'b0, geom.width, 1'b0};
         default: data_bytes = {geom.width, 2'b00};
      endcase
      row_bytes = (data_bytes + 15'd3) & ~15'd3;

      in_data   = {1'b0, bir_cur} < data_bytes;
      word      = {8'b0, acc_cur} | ({24'b0, req_data_byte} << {bip_cur, 3'b000});
      last_byte = ({1'b0, bip_cur} + 3'd1) >= geom.bpp;
      emit      = in_data && last_byte;

      // destination position, clamped if limits shrank mid-frame
      wm1 = 12'(geom.width - 13'd1);
      hm1 = 12'(geom.height - 13'd1);
      c   = ({1'b0, col_cur} < geom.width)  ? col_cur : wm1;
      r   = ({1'b0, row_cur} < geom.height) ? row_cur : hm1;
      push_task.word    = word;
      push_task.dst_row = geom.bottom_up ? hm1 - r : r;
      push_task.column  = c;
      push_task.last    = (r == hm1) && (c == wm1);
      push              = accept && emit;

      acc_in = acc_cur;
      bip_in = bip_cur;
      col_in = col_cur;
      row_in = row_cur;
      if (in_data) begin
         if (last_byte) begin
            acc_in = '0;
            bip_in = '0;
            col_in = col_cur + 12'd1;
         end else begin
            acc_in = word[23:0];
            bip_in = bip_cur + 2'd1;
         end
      end

      bir_inc = {1'b0, bir_cur} + 15'd1;
      row_nxt = row_cur + 12'd1;
      if (bir_inc >= row_bytes || bir_inc[14]) begin
         bir_in = '0;
         col_in = '0;
         acc_in = '0;
         bip_in = '0;
         row_in = ({1'b0, row_nxt} >= geom.height) ? '0 : row_nxt;
      end else begin
         bir_in = bir_inc[13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bip_ff <= '0;
         bir_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
         bip_ff <= bip_in;
         bir_ff <= bir_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // a row always starts on a pixel boundary
   a_row_start_aligned: assert property (@(posedge clock) disable iff (reset)
      (bir_ff == '0) |-> (bip_ff == '0))
      else $error("row start with partial pixel");

endmodule

### sv/bpu_queue.sv
// short pixel queue between the assembler and the scaler
module bpu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bpu_pkg::bpu_task_type push_task,
   input  logic                  pop,
   output bpu_pkg::bpu_task_type pop_task,
   output logic                  full,
   output logic                  empty
);
   import bpu_pkg::*;

   bpu_task_type            entry_ff [BPU_QUEUE_DEPTH];
   logic [BPU_QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [BPU_QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [BPU_QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == BPU_QCNT_W'(BPU_QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_task = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == BPU_QPTR_W'(BPU_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == BPU_QPTR_W'(BPU_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_task;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BPU_QCNT_W'(BPU_QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");

endmodule

### sv/bpu_back.sv
// per-channel scaling by bit-serial division and result register
module bpu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [12:0]            width,
   input  bpu_pkg::bpu_masks_type masks,
   input  logic                   queue_empty,
   input  bpu_pkg::bpu_task_type  pop_task,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_red,
   output logic [7:0]             rsp_green,
   output logic [7:0]             rsp_blue,
   output logic [7:0]             rsp_alpha,
   output logic                   rsp_has_alpha,
   output logic [23:0]            rsp_pixel_index,
   output logic                   rsp_last_pixel
);
   import bpu_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } bk_state_type;

   bk_state_type            state_ff, state_in;
   logic [BPU_STEP_W-1:0]   step_ff, step_in;
   logic [31:0]             rem_ff  [BPU_CHANNELS];
   logic [31:0]             rem_in  [BPU_CHANNELS];
   logic [7:0]              low_ff  [BPU_CHANNELS];
   logic [7:0]              low_in  [BPU_CHANNELS];
   logic [7:0]              quot_ff [BPU_CHANNELS];
   logic [7:0]              quot_in [BPU_CHANNELS];
   logic [7:0]              chan_out[BPU_CHANNELS];
   logic [23:0]             index_ff, index_in;
   logic                    last_ff, last_in;
   logic                    valid_ff, valid_in;
   logic [7:0]              red_ff, green_ff, blue_ff, alpha_ff;
   logic                    has_alpha_ff;
   logic [23:0]             pix_ff;
   logic                    lastp_ff;
   logic                    out_free;
   logic                    finish;
   logic                    advance;
   logic [31:0]             masked  [BPU_CHANNELS];
   logic [39:0]             numer   [BPU_CHANNELS];
   bpu_div_type             div_r   [BPU_CHANNELS];
   logic [24:0]             row_base;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = (state_ff == BK_IDLE) && !queue_empty;
   assign advance  = (state_ff == BK_RUN) &&
                     ((step_ff != BPU_STEP_W'(BPU_QUOT_BITS - 1)) || out_free);
   assign finish   = advance && (step_ff == BPU_STEP_W'(BPU_QUOT_BITS - 1));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      index_in = index_ff;
      last_in  = last_ff;
      row_base = {13'b0, pop_task.dst_row} * {12'b0, width};
      for (int ch = 0; ch < BPU_CHANNELS; ch++) begin
         // value*255 as (value<<8)-value; quotient fits in eight bits
         masked[ch]   = pop_task.word & masks[ch];
         numer[ch]    = {masked[ch], 8'b0} - {8'b0, masked[ch]};
         div_r[ch]    = bpu_div_step(rem_ff[ch], low_ff[ch][7], masks[ch]);
         chan_out[ch] = (masks[ch] == '0) ? 8'd0 : {quot_ff[ch][6:0], div_r[ch].qbit};
         rem_in[ch]   = rem_ff[ch];
         low_in[ch]   = low_ff[ch];
         quot_in[ch]  = quot_ff[ch];
         if (pop) begin
            rem_in[ch]  = numer[ch][39:8];
            low_in[ch]  = numer[ch][7:0];
            quot_in[ch] = '0;
         end else if (advance) begin
            rem_in[ch]  = div_r[ch].rem;
            low_in[ch]  = {low_ff[ch][6:0], 1'b0};
            quot_in[ch] = {quot_ff[ch][6:0], div_r[ch].qbit};
         end
      end
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               state_in = BK_RUN;
               step_in  = '0;
               index_in = 24'(row_base + {13'b0, pop_task.column});
               last_in  = pop_task.last;
            end
         end
         BK_RUN: begin
            if (finish) begin
               state_in = BK_IDLE;
            end else if (advance) begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      valid_in = valid_ff;
      if (finish) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      last_ff  <= last_in;
      for (int ch = 0; ch < BPU_CHANNELS; ch++) begin
         rem_ff[ch]  <= rem_in[ch];
         low_ff[ch]  <= low_in[ch];
         quot_ff[ch] <= quot_in[ch];
      end
      if (finish) begin
         red_ff       <= chan_out[BPU_CH_RED];
         green_ff     <= chan_out[BPU_CH_GREEN];
         blue_ff      <= chan_out[BPU_CH_BLUE];
         alpha_ff     <= chan_out[BPU_CH_ALPHA];
         has_alpha_ff <= (masks[BPU_CH_ALPHA] != '0);
         pix_ff       <= index_ff;
         lastp_ff     <= last_ff;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_alpha       = alpha_ff;
   assign rsp_has_alpha   = has_alpha_ff;
   assign rsp_pixel_index = pix_ff;
   assign rsp_last_pixel  = lastp_ff;

   a_result_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == BK_RUN))
      else $error("result appeared without a finished division");

endmodule

### sv/bitfield_pixel_unpacker.sv
// top level of the bitfield pixel unpacker: config registers and block wiring
//
// usage:
//  - req channel: one raw pixel-array byte per beat, padding bytes included;
//    req_frame_start marks the first byte of a new array and restarts all counters
//  - rsp channel: one beat per completed pixel with r/g/b/a scaled to 8 bits,
//    has_alpha, destination pixel index (rows flipped for bottom-up images)
//    and a last flag on the final pixel of the image
//  - csr port: plain write, one register per index, taken while the block is idle (user's duty, no check)
// throughput: the byte side takes one byte per cycle until the pixel queue
//  (four entries) fills; the scaler loads a pixel, then works out one quotient
//  bit at a time, eight in all, in each of the four channel dividers, and takes
//  the next pixel only once those are done and the result register is free
// reset: synchronous, clears counters, queue and result valid; registers go
//  to width 1, height 1, four bytes per pixel, bottom-up, all masks zero
// stall: a stalled result holds in the output register; the scaler then waits,
//  the queue fills and req_stall rises, with no beat lost
module bitfield_pixel_unpacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_has_alpha,
   output logic [23:0] rsp_pixel_index,
   output logic        rsp_last_pixel,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import bpu_pkg::*;

   // raw configuration registers
   logic [12:0]   width_ff;
   logic [12:0]   height_ff;
   logic [2:0]    bpp_ff;
   logic          bottom_up_ff;
   bpu_masks_type masks_ff;

   bpu_geom_type  geom;
   bpu_task_type  push_task, pop_task;
   logic          push, pop, queue_full, queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 13'd1;
         height_ff    <= 13'd1;
         bpp_ff       <= BPU_MAX_BPP;
         bottom_up_ff <= 1'b1;
         masks_ff     <= '0;
      end else if (csr_write_en) begin
         case (bpu_reg_type'(csr_index))
            BPU_REG_WIDTH:      width_ff                  <= csr_data[12:0];
            BPU_REG_HEIGHT:     height_ff                 <= csr_data[12:0];
            BPU_REG_BPP:        bpp_ff                    <= csr_data[2:0];
            BPU_REG_BOTTOM_UP:  bottom_up_ff              <= csr_data[0];
            BPU_REG_RED_MASK:   masks_ff[BPU_CH_RED]      <= csr_data;
            BPU_REG_GREEN_MASK: masks_ff[BPU_CH_GREEN]    <= csr_data;
            BPU_REG_BLUE_MASK:  masks_ff[BPU_CH_BLUE]     <= csr_data;
            BPU_REG_ALPHA_MASK: masks_ff[BPU_CH_ALPHA]    <= csr_data;
            default: ;
         endcase
      end
   end

   // zero counts as one, oversize values saturate
   always_comb begin
      geom.width     = (width_ff == '0) ? 13'd1 :
                       ((width_ff > BPU_MAX_WIDTH) ? BPU_MAX_WIDTH : width_ff);
      geom.height    = (height_ff == '0) ? 13'd1 :
                       ((height_ff > BPU_MAX_HEIGHT) ? BPU_MAX_HEIGHT : height_ff);
      geom.bpp       = (bpp_ff == '0) ? 3'd1 :
                       ((bpp_ff > BPU_MAX_BPP) ? BPU_MAX_BPP : bpp_ff);
      geom.bottom_up = bottom_up_ff;
   end

   // byte side: assembles pixels and tags them with their position
   bpu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .req_stall       (req_stall),
      .queue_full      (queue_full),
      .push            (push),
      .push_task       (push_task)
   );

   // decouples byte intake from the multi-cycle scaler
   bpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .pop_task  (pop_task),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // pixel side: scales the four channels and holds the result beat
   bpu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .width           (geom.width),
      .masks           (masks_ff),
      .queue_empty     (queue_empty),
      .pop_task        (pop_task),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_has_alpha   (rsp_has_alpha),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

### verif/tb_bitfield_pixel_unpacker.sv
`timescale 1ns / 1ps
// self-checking testbench for the bitfield pixel unpacker: byte driver, pixel predictor, checker
module tb_bitfield_pixel_unpacker;
   import bpu_pkg::*;

   localparam int IDLE_LIMIT    = 4000;  // cycles with no beat on either side
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 20;    // scaler latency plus margin
   localparam int RANDOM_BYTES  = 626;

   // one raw byte of the pixel array as offered on the req side
   typedef struct packed {
      logic [7:0] data;
      logic       frame_start;
   } raw_byte_type;

   // one decoded pixel as seen on the rsp side
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        has_alpha;
      logic [23:0] pixel_index;
      logic        last_pixel;
   } pixel_type;

   typedef enum {
      SETUP_RANDOM,
      SETUP_PRESSURE,
      SETUP_WIDEST,
      SETUP_ZERO,
      SETUP_OVERRANGE
   } setup_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_has_alpha;
   logic [23:0] rsp_pixel_index;
   logic        rsp_last_pixel;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [31:0] csr_data = 32'd0;

   // predictor copy of the registers
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   logic [2:0]  cfg_bpp;
   logic        cfg_bottom_up;
   logic [31:0] cfg_mask [BPU_CHANNELS];

   // predictor copy of the stream position
   logic [31:0] acc_word;
   logic [1:0]  pixel_byte;
   logic [13:0] row_byte;
   logic [11:0] column;
   logic [11:0] stored_row;

   raw_byte_type bytes_to_send [$];
   pixel_type    pixels_due [$];

   int unsigned bytes_taken    = 0;
   int unsigned pixels_checked = 0;
   int unsigned image_ends     = 0;
   int unsigned setups         = 0;
   int unsigned mismatch_count = 0;
   int unsigned random_bytes   = 0;
   int unsigned idle_cycles    = 0;

   // sender burst state
   int burst_left = 1;
   int gap_left   = 0;

   // receiver stall pattern and long hold-off
   int hold_ticket  = 0;
   int holds_served = 0;
   int hold_left    = 0;
   int seg_left     = 0;
   int seg_mode     = 0;

   bitfield_pixel_unpacker DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_has_alpha   (rsp_has_alpha),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // pixel predictor
   // ---------------------------------------------------------------

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function int unsigned eff_width();
      return clamp_to(32'(cfg_width), 32'(BPU_MAX_WIDTH));
   endfunction

   function int unsigned eff_height();
      return clamp_to(32'(cfg_height), 32'(BPU_MAX_HEIGHT));
   endfunction

   function int unsigned eff_bpp();
      return clamp_to(32'(cfg_bpp), 32'(BPU_MAX_BPP));
   endfunction

   // stored row length, data rounded up to a multiple of four bytes
   function int unsigned stored_row_bytes();
      return ((eff_width() * eff_bpp() + 3) / 4) * 4;
   endfunction

   // mask, shift down to the lowest mask bit, scale to 0..255 by exact division
   function automatic logic [7:0] scale_to_8bit(logic [31:0] word, logic [31:0] mask);
      int unsigned sh;
      logic [63:0] field;
      logic [63:0] top;
      if (mask == 32'd0) return 8'h00;
      sh = 0;
      while (sh < 31 && mask[sh] == 1'b0) sh++;
      field = 64'((word & mask) >> sh);
      top   = 64'(mask >> sh);
      return 8'((field * 64'd255) / top);
   endfunction

   task clear_position();
      acc_word   = 32'd0;
      pixel_byte = 2'd0;
      row_byte   = 14'd0;
      column     = 12'd0;
      stored_row = 12'd0;
   endtask

   // one accepted byte: advance the position and queue the pixel it completes
   task automatic decode_byte(logic [7:0] data, logic start);
      int unsigned w, h, bpp, pos, c, r, dr;
      pixel_type px;
      w   = eff_width();
      h   = eff_height();
      bpp = eff_bpp();
      if (start) clear_position();
      if (row_byte < w * bpp) begin
         pos = 32'(pixel_byte);
         acc_word = acc_word | (32'(data) << (8 * pos));
         if (pos + 1 >= bpp) begin
            // counters left beyond a shrunken image clamp to its last column/row
            c  = (column < w) ? 32'(column) : w - 1;
            r  = (stored_row < h) ? 32'(stored_row) : h - 1;
            dr = cfg_bottom_up ? h - 1 - r : r;
            px.red         = scale_to_8bit(acc_word, cfg_mask[BPU_CH_RED]);
            px.green       = scale_to_8bit(acc_word, cfg_mask[BPU_CH_GREEN]);
            px.blue        = scale_to_8bit(acc_word, cfg_mask[BPU_CH_BLUE]);
            px.alpha       = scale_to_8bit(acc_word, cfg_mask[BPU_CH_ALPHA]);
            px.has_alpha   = (cfg_mask[BPU_CH_ALPHA] != 32'd0);
            px.pixel_index = 24'(dr * w + c);
            px.last_pixel  = (r == h - 1) && (c == w - 1);
            pixels_due.push_back(px);
            acc_word   = 32'd0;
            pixel_byte = 2'd0;
            column     = column + 12'd1;
         end else begin
            pixel_byte = 2'(pos + 1);
         end
      end
      row_byte = row_byte + 14'd1;
      if (row_byte >= stored_row_bytes() || row_byte == 14'd0) begin
         // row end: padding done, next stored row, wrap after the last one
         row_byte   = 14'd0;
         column     = 12'd0;
         acc_word   = 32'd0;
         pixel_byte = 2'd0;
         stored_row = stored_row + 12'd1;
         if (stored_row >= h) stored_row = 12'd0;
      end
   endtask

   // ---------------------------------------------------------------
   // req side: bursts of bytes, some with random gaps between them
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_bytes
      raw_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bytes_to_send.size() != 0) begin
            nxt = bytes_to_send.pop_front();
            req_valid       <= 1'b1;
            req_data_byte   <= nxt.data;
            req_frame_start <= nxt.frame_start;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               // half the bursts run straight into the next one
               gap_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 6) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // rsp side: stall segments of varying density, plus the long hold-off
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_ticket) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 2);
            seg_left = $urandom_range(20, 200);
         end else begin
            seg_left--;
         end
         case (seg_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 9) < 7);
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // checker: predict on every accepted byte, compare every pixel beat
   // ---------------------------------------------------------------

   task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("pixel %0d %s: expected %0h, got %0h", pixels_checked, name, want, seen);
      end
   endtask

   always @(posedge clock) begin : watch_beats
      pixel_type seen;
      pixel_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_has_alpha,
                    rsp_pixel_index, rsp_last_pixel};
            if (seen.last_pixel === 1'b1) image_ends++;
            if (pixels_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("pixel beat with none expected, index %0h", seen.pixel_index);
            end else begin
               want = pixels_due.pop_front();
               check_field("red", 32'(want.red), 32'(seen.red));
               check_field("green", 32'(want.green), 32'(seen.green));
               check_field("blue", 32'(want.blue), 32'(seen.blue));
               check_field("alpha", 32'(want.alpha), 32'(seen.alpha));
               check_field("has_alpha", 32'(want.has_alpha), 32'(seen.has_alpha));
               check_field("pixel_index", 32'(want.pixel_index), 32'(seen.pixel_index));
               check_field("last_pixel", 32'(want.last_pixel), 32'(seen.last_pixel));
               pixels_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            decode_byte(req_data_byte, req_frame_start);
         end
      end
   end

   // watchdog: too long with no beat taken on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("no beat for %0d cycles, %0d pixels outstanding",
                  IDLE_LIMIT, pixels_due.size());
         $display("bitfield_pixel_unpacker regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // register write, mirrored into the predictor at once (block is idle)
   task automatic write_reg(bpu_reg_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      case (idx)
         BPU_REG_WIDTH:      cfg_width = value[12:0];
         BPU_REG_HEIGHT:     cfg_height = value[12:0];
         BPU_REG_BPP:        cfg_bpp = value[2:0];
         BPU_REG_BOTTOM_UP:  cfg_bottom_up = value[0];
         BPU_REG_RED_MASK:   cfg_mask[BPU_CH_RED] = value;
         BPU_REG_GREEN_MASK: cfg_mask[BPU_CH_GREEN] = value;
         BPU_REG_BLUE_MASK:  cfg_mask[BPU_CH_BLUE] = value;
         BPU_REG_ALPHA_MASK: cfg_mask[BPU_CH_ALPHA] = value;
         default: ;
      endcase
   endtask

   task close_writes();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic push_byte(logic [7:0] data, logic start);
      bytes_to_send.push_back({data, start});
   endtask

   // all bytes taken and all pixels back, then a settling wait
   task wait_idle();
      @(negedge clock);
      while (bytes_to_send.size() != 0 || req_valid || pixels_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_data();
      if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
      return 8'($urandom);
   endfunction

   // zero, full, one-bit, top bit, contiguous field or arbitrary scatter
   function automatic logic [31:0] random_mask();
      int unsigned lo, len;
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hffffffff;
         2: return 32'd1 << $urandom_range(0, 31);
         3: return 32'h80000000;
         4: begin
            lo  = $urandom_range(0, 31);
            len = $urandom_range(1, 32 - lo);
            return 32'(((64'd1 << len) - 64'd1) << lo);
         end
         default: return $urandom;
      endcase
   endfunction

   // mostly small sizes, now and then zero, the maximum or beyond it
   function automatic int unsigned pick_span(int unsigned small_hi);
      if ($urandom_range(0, 4) != 0) return $urandom_range(1, small_hi);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 4096;
         2: return 8191;
         default: return $urandom_range(4097, 8191);
      endcase
   endfunction

   // one register setup followed by a few frames of random pixel data
   task automatic run_setup(setup_kind_type kind);
      int unsigned w_reg, h_reg, bpp_reg, bu_reg, frame_len, n, nframes;
      logic start;
      setups++;
      bu_reg = $urandom_range(0, 1);
      case (kind)
         SETUP_WIDEST: begin
            w_reg = 4096; h_reg = 4096; bpp_reg = 4; bu_reg = 1;
         end
         SETUP_ZERO: begin
            w_reg = 0; h_reg = 0; bpp_reg = 0; bu_reg = 0;
         end
         SETUP_OVERRANGE: begin
            w_reg = 8191; h_reg = 8191; bpp_reg = $urandom_range(5, 7);
         end
         SETUP_PRESSURE: begin
            w_reg = 4; h_reg = 4; bpp_reg = $urandom_range(1, 2);
         end
         default: begin
            w_reg = pick_span(5); h_reg = pick_span(4); bpp_reg = $urandom_range(0, 7);
         end
      endcase
      // junk above each narrow register must be ignored
      write_reg(BPU_REG_WIDTH, (32'($urandom) & 32'hffffe000) | w_reg);
      write_reg(BPU_REG_HEIGHT, (32'($urandom) & 32'hffffe000) | h_reg);
      write_reg(BPU_REG_BPP, (32'($urandom) & 32'hfffffff8) | bpp_reg);
      write_reg(BPU_REG_BOTTOM_UP, (32'($urandom) & 32'hfffffffe) | bu_reg);
      write_reg(BPU_REG_RED_MASK, random_mask());
      write_reg(BPU_REG_GREEN_MASK, random_mask());
      write_reg(BPU_REG_BLUE_MASK, random_mask());
      write_reg(BPU_REG_ALPHA_MASK, ($urandom_range(0, 1) == 1) ? 32'd0 : random_mask());
      close_writes();

      frame_len = stored_row_bytes() * eff_height();
      nframes   = (kind == SETUP_PRESSURE) ? 2 : $urandom_range(1, 3);
      // receiver holds off while two whole frames are offered
      if (kind == SETUP_PRESSURE) hold_ticket++;
      for (int f = 0; f < nframes; f++) begin
         // no frame start: carry on mid-frame or let the image wrap on its own
         if (kind == SETUP_PRESSURE)
            start = 1'b1;
         else if (f == 0)
            start = ($urandom_range(0, 4) != 0);
         else
            start = ($urandom_range(0, 2) != 0);
         n = (frame_len <= 96) ? frame_len : $urandom_range(8, 40);
         // broken frame, cut short before its end
         if (kind != SETUP_PRESSURE && $urandom_range(0, 9) == 0) n = $urandom_range(1, n);
         for (int i = 0; i < n; i++)
            push_byte(random_data(), (i == 0) ? start : ($urandom_range(0, 49) == 0));
         random_bytes += n;
      end
      wait_idle();
   endtask

   initial begin : stimulus
      // directed 2x2 frame, 3 bytes per pixel, 2 padding bytes per row
      localparam logic [127:0] DIRECTED_FRAME = 128'h000000_ffffff_aa55_123456_807f01_0ff0;

      cfg_width     = 13'd1;
      cfg_height    = 13'd1;
      cfg_bpp       = 3'd4;
      cfg_bottom_up = 1'b1;
      foreach (cfg_mask[i]) cfg_mask[i] = 32'd0;
      clear_position();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values: 1x1 image, four bytes per pixel, all masks zero
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      wait_idle();

      setups++;
      write_reg(BPU_REG_WIDTH, 32'd2);
      write_reg(BPU_REG_HEIGHT, 32'd2);
      write_reg(BPU_REG_BPP, 32'd3);
      write_reg(BPU_REG_BOTTOM_UP, 32'd1);
      write_reg(BPU_REG_RED_MASK, 32'h00ff0000);
      write_reg(BPU_REG_GREEN_MASK, 32'h0000ff00);
      write_reg(BPU_REG_BLUE_MASK, 32'h000000ff);
      write_reg(BPU_REG_ALPHA_MASK, 32'd0);
      close_writes();
      for (int i = 0; i < 16; i++)
         push_byte(DIRECTED_FRAME[127 - 8 * i -: 8], i == 0);
      // past the end: new image without frame start, then a frame start mid-pixel
      push_byte(8'h3c, 1'b0);
      push_byte(8'hc3, 1'b0);
      push_byte(8'h5a, 1'b1);
      push_byte(8'ha5, 1'b0);
      push_byte(8'h99, 1'b0);
      wait_idle();

      run_setup(SETUP_WIDEST);
      run_setup(SETUP_ZERO);
      run_setup(SETUP_OVERRANGE);
      run_setup(SETUP_PRESSURE);
      while (random_bytes < RANDOM_BYTES)
         run_setup(SETUP_RANDOM);

      $display("covered %0d bytes over %0d register setups, %0d pixels compared, %0d image ends",
               bytes_taken, setups, pixels_checked, image_ends);
      $display("field mismatches and stray pixels: %0d", mismatch_count);
      if (mismatch_count == 0 && pixels_due.size() == 0)
         $display("bitfield_pixel_unpacker regression: pass");
      else
         $display("bitfield_pixel_unpacker regression: fail");
      $finish;
   end

endmodule

### files.f
sv/bpu_pkg.sv
sv/bpu_front.sv
sv/bpu_queue.sv
sv/bpu_back.sv
sv/bitfield_pixel_unpacker.sv
verif/tb_bitfield_pixel_unpacker.sv
